// ----- src/ahs_pkg.sv -----
// ----------------------------------------------------------------------------
// Hit segmenter package
// Shared constants, command codes, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ahs_pkg;
    localparam int HitSlots     = 16;
    localparam int HitDepth     = 16384;
    localparam int PrerollDepth = 2048;

    localparam logic [10:0] LookbackRst  = 11'd1756;
    localparam logic [13:0] MinHitRst    = 14'd1000;
    localparam logic [22:0] ThresholdRst = 23'd83886;
    localparam logic [15:0] MinOffRst    = 16'd2205;

    localparam int InDataW  = 72;
    localparam int InUserW  = 2;
    localparam int OutDataW = 88;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LOOKBACK  = 2'd0,
        REG_MIN_HIT   = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_MIN_OFF   = 2'd3
    } reg_idx_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_COPY = 7'b0001000,
        S_REC  = 7'b0010000,
        S_RDW  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ----- src/audio_hit_segmenter.sv -----
// ----------------------------------------------------------------------------
// Audio hit segmenter
// Cuts drum hits from an audio stream into slots with a pre-roll copy.
// ----------------------------------------------------------------------------
// A sample item passes S_EXEC, S_REC and S_FIN (S_REC only while a slot is
// free); when a hit opens it also passes S_MOD and S_COPY before S_REC, and
// the copy moves one pre-roll entry per cycle through the ring read port. Flush
// passes S_EXEC and S_FIN, read S_EXEC, S_RDW and S_FIN.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted. Reset is synchronous, active low;
// the pre-roll ring is tracked by a fill count, so no clearing pass is needed.
`default_nettype none
module audio_hit_segmenter
    import ahs_pkg::*;
#(
    parameter int HIT_SLOTS     = ahs_pkg::HitSlots,
    parameter int HIT_DEPTH     = ahs_pkg::HitDepth,
    parameter int PREROLL_DEPTH = ahs_pkg::PrerollDepth
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sample[23:0], amp[46:24], trigger[47], read_slot[51:48], read_pos[65:52]
    input  wire logic [ahs_pkg::InDataW-1:0]   s_tdata,
    // cmd[1:0]
    input  wire logic [ahs_pkg::InUserW-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_data[23:0], read_valid[24], hit_done[25], done_slot[29:26],
    // done_length[44:30], done_onset[76:45], recording[77], hits_stored[82:78]
    output logic      [ahs_pkg::OutDataW-1:0]  m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    localparam int SW  = (HIT_SLOTS > 1) ? $clog2(HIT_SLOTS) : 1;
    localparam int CW  = $clog2(HIT_SLOTS + 1);
    localparam int PW  = $clog2(PREROLL_DEPTH);
    localparam int FW  = $clog2(PREROLL_DEPTH + 1);
    localparam int WPW = $clog2(HIT_DEPTH + 1);
    localparam int AW  = $clog2(HIT_SLOTS * HIT_DEPTH);

    state_t state_reg, state_next;

    logic [1:0]  cmd_reg;
    logic [23:0] sample_reg;
    logic [22:0] amp_reg;
    logic        trig_reg;
    logic [3:0]  rslot_reg;
    logic [13:0] rpos_reg;

    logic [10:0] lb_reg;
    logic [13:0] minhit_reg;
    logic [22:0] thr_reg;
    logic [15:0] minoff_reg;

    logic [PW-1:0]  wr_reg, wr_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [31:0]    scnt_reg, scnt_next;
    logic [CW-1:0]  sc_reg, sc_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [WPW-1:0] wp_reg, wp_next;
    logic           active_reg, active_next;
    logic [15:0]    quiet_reg, quiet_next;
    logic [31:0]    onset_reg, onset_next;
    logic [10:0]    m_reg, m_next;
    logic [PW-1:0]  idx_reg, idx_next;
    logic [PW-1:0]  delay_reg, delay_next;
    logic [10:0]    cnt_reg, cnt_next;
    logic           pend_reg, pend_next;
    logic           pok_reg, pok_next;
    logic           evd_reg, evd_next;
    logic [3:0]     evs_reg, evs_next;
    logic [14:0]    evl_reg, evl_next;
    logic [31:0]    evo_reg, evo_next;
    logic           rv_reg, rv_next;
    logic [23:0]    rd_reg, rd_next;
    logic           mv_reg, mv_next;
    logic [OutDataW-1:0] md_reg, md_next;

    logic [WPW-1:0] slen_mem [HIT_SLOTS];
    logic           st_we;
    logic [WPW-1:0] st_len;

    logic           ring_we;
    logic [PW-1:0]  ring_raddr;
    logic [23:0]    ring_rd;
    logic           hs_we;
    logic [AW-1:0]  hs_waddr, hs_raddr, hs_raddr_c;
    logic [23:0]    hs_wdata, hs_rd;

    logic [31:0]    scnt_inc, onset_c, len_c, rd_lin;
    logic [WPW-1:0] wp_rec;
    logic [15:0]    quiet_inc;
    logic [FW-1:0]  eff_c;
    logic [PW-1:0]  mm_c;
    logic           cfg_we;
    reg_idx_t       cfg_idx;

    ahs_ram #(.DEPTH(PREROLL_DEPTH), .WIDTH(24)) u_ring (
        .aclk(aclk), .we(ring_we), .waddr(wr_reg), .wdata(sample_reg),
        .raddr(ring_raddr), .rdata(ring_rd)
    );

    ahs_ram #(.DEPTH(HIT_SLOTS * HIT_DEPTH), .WIDTH(24)) u_store (
        .aclk(aclk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
        .raddr(hs_raddr), .rdata(hs_rd)
    );

    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_LOOKBACK:  prdata = 32'(lb_reg);
            REG_MIN_HIT:   prdata = 32'(minhit_reg);
            REG_THRESHOLD: prdata = 32'(thr_reg);
            REG_MIN_OFF:   prdata = 32'(minoff_reg);
            default:       prdata = 32'd0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    assign scnt_inc  = scnt_reg + 32'd1;
    assign onset_c   = (scnt_inc > 32'(lb_reg)) ? scnt_inc - 32'(lb_reg) : 32'd0;
    assign len_c     = 32'(wp_reg) - 32'(lb_reg);
    assign quiet_inc = (quiet_reg == 16'hFFFF) ? quiet_reg : quiet_reg + 16'd1;
    assign eff_c     = (delay_reg == '0) ? FW'(PREROLL_DEPTH) : FW'(delay_reg);
    assign mm_c      = PW'(m_reg);
    assign rd_lin    = 32'(rslot_reg) * 32'(HIT_DEPTH) + 32'(rpos_reg);
    assign hs_raddr_c = AW'(rd_lin);
    assign hs_raddr  = hs_raddr_c;
    assign ring_raddr = idx_reg;

    always_comb begin
        state_next  = state_reg;
        wr_next     = wr_reg;
        fill_next   = fill_reg;
        scnt_next   = scnt_reg;
        sc_next     = sc_reg;
        base_next   = base_reg;
        wp_next     = wp_reg;
        active_next = active_reg;
        quiet_next  = quiet_reg;
        onset_next  = onset_reg;
        m_next      = m_reg;
        idx_next    = idx_reg;
        delay_next  = delay_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        pok_next    = pok_reg;
        evd_next    = evd_reg;
        evs_next    = evs_reg;
        evl_next    = evl_reg;
        evo_next    = evo_reg;
        rv_next     = rv_reg;
        rd_next     = rd_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        st_we       = 1'b0;
        st_len      = wp_reg;
        ring_we     = 1'b0;
        hs_we       = 1'b0;
        hs_waddr    = base_reg + AW'(wp_reg);
        hs_wdata    = sample_reg;
        wp_rec      = wp_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    evd_next   = 1'b0;
                    evs_next   = '0;
                    evl_next   = '0;
                    evo_next   = '0;
                    rv_next    = 1'b0;
                    rd_next    = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                case (cmd_t'(cmd_reg))
                    CMD_SAMPLE: begin
                        if (32'(sc_reg) < 32'(HIT_SLOTS)) begin
                            scnt_next = scnt_inc;
                            ring_we   = 1'b1;
                            wr_next   = (32'(wr_reg) == 32'(PREROLL_DEPTH - 1)) ?
                                        '0 : wr_reg + PW'(1);
                            if (32'(fill_reg) < 32'(PREROLL_DEPTH)) begin
                                fill_next = fill_reg + FW'(1);
                            end
                            state_next = S_REC;
                            if (trig_reg && !active_reg) begin
                                active_next = 1'b1;
                                onset_next  = onset_c;
                                wp_next     = '0;
                                m_next      = lb_reg;
                                state_next  = S_MOD;
                            end else if (trig_reg && 32'(wp_reg) > 32'(lb_reg)) begin
                                if (len_c > 32'(minhit_reg)) begin
                                    st_we     = 1'b1;
                                    st_len    = WPW'(len_c);
                                    evd_next  = 1'b1;
                                    evs_next  = 4'(sc_reg);
                                    evl_next  = 15'(len_c);
                                    evo_next  = onset_reg;
                                    sc_next   = sc_reg + CW'(1);
                                    base_next = base_reg + AW'(HIT_DEPTH);
                                end
                                if (32'(sc_next) >= 32'(HIT_SLOTS)) begin
                                    active_next = 1'b0;
                                end else begin
                                    onset_next = onset_c;
                                    wp_next    = '0;
                                    quiet_next = '0;
                                    m_next     = lb_reg;
                                    state_next = S_MOD;
                                end
                            end
                        end
                    end
                    CMD_FLUSH: begin
                        if (active_reg) begin
                            if (32'(wp_reg) > 32'(minhit_reg) &&
                                32'(sc_reg) < 32'(HIT_SLOTS)) begin
                                st_we    = 1'b1;
                                evd_next = 1'b1;
                                evs_next = 4'(sc_reg);
                                evl_next = 15'(wp_reg);
                                evo_next = onset_reg;
                                sc_next  = sc_reg + CW'(1);
                                base_next = base_reg + AW'(HIT_DEPTH);
                            end
                            active_next = 1'b0;
                            quiet_next  = '0;
                        end
                    end
                    CMD_READ: begin
                        rv_next = (32'(rslot_reg) < 32'(sc_reg)) &&
                                  (32'(rslot_reg) < 32'(HIT_SLOTS)) &&
                                  (32'(rpos_reg) < 32'(slen_mem[SW'(rslot_reg)])) &&
                                  (32'(rpos_reg) < 32'(HIT_DEPTH));
                        state_next = S_RDW;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_MOD: begin
                if (32'(m_reg) >= 32'(PREROLL_DEPTH)) begin
                    m_next = 11'(32'(m_reg) - 32'(PREROLL_DEPTH));
                end else begin
                    delay_next = mm_c;
                    idx_next   = (wr_reg >= mm_c) ? wr_reg - mm_c :
                                 PW'(32'(wr_reg) + 32'(PREROLL_DEPTH) - 32'(mm_c));
                    cnt_next   = lb_reg;
                    state_next = S_COPY;
                end
            end
            S_COPY: begin
                if (cnt_reg != '0) begin
                    pend_next  = 1'b1;
                    pok_next   = (eff_c <= fill_reg);
                    cnt_next   = cnt_reg - 11'd1;
                    delay_next = (delay_reg == '0) ? PW'(PREROLL_DEPTH - 1) :
                                 delay_reg - PW'(1);
                    idx_next   = (32'(idx_reg) == 32'(PREROLL_DEPTH - 1)) ?
                                 '0 : idx_reg + PW'(1);
                end else if (!pend_reg) begin
                    state_next = S_REC;
                end
                if (pend_reg && 32'(wp_reg) < 32'(HIT_DEPTH)) begin
                    hs_we    = 1'b1;
                    hs_wdata = pok_reg ? ring_rd : 24'd0;
                    wp_next  = wp_reg + WPW'(1);
                end
            end
            S_REC: begin
                state_next = S_FIN;
                if (active_reg && 32'(sc_reg) < 32'(HIT_SLOTS)) begin
                    if (32'(wp_reg) < 32'(HIT_DEPTH)) begin
                        hs_we  = 1'b1;
                        wp_rec = wp_reg + WPW'(1);
                    end
                    wp_next = wp_rec;
                    if (amp_reg < thr_reg) begin
                        quiet_next = quiet_inc;
                        if (quiet_inc >= minoff_reg &&
                            32'(wp_rec) > 32'(minhit_reg)) begin
                            st_we       = 1'b1;
                            st_len      = wp_rec;
                            evd_next    = 1'b1;
                            evs_next    = 4'(sc_reg);
                            evl_next    = 15'(wp_rec);
                            evo_next    = onset_reg;
                            sc_next     = sc_reg + CW'(1);
                            base_next   = base_reg + AW'(HIT_DEPTH);
                            active_next = 1'b0;
                            quiet_next  = '0;
                        end
                    end else begin
                        quiet_next = '0;
                    end
                end
            end
            S_RDW: begin
                rd_next    = rv_reg ? hs_rd : 24'd0;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {5'd0, 5'(sc_reg), active_reg, evo_reg, evl_reg,
                                  evs_reg, evd_reg, rv_reg, rd_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            lb_reg     <= LookbackRst;
            minhit_reg <= MinHitRst;
            thr_reg    <= ThresholdRst;
            minoff_reg <= MinOffRst;
            wr_reg     <= '0;
            fill_reg   <= '0;
            scnt_reg   <= '0;
            sc_reg     <= '0;
            base_reg   <= '0;
            wp_reg     <= '0;
            active_reg <= 1'b0;
            quiet_reg  <= '0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wr_reg     <= wr_next;
            fill_reg   <= fill_next;
            scnt_reg   <= scnt_next;
            sc_reg     <= sc_next;
            base_reg   <= base_next;
            wp_reg     <= wp_next;
            active_reg <= active_next;
            quiet_reg  <= quiet_next;
            pend_reg   <= pend_next;
            mv_reg     <= mv_next;
            if (cfg_we) begin
                case (cfg_idx)
                    REG_LOOKBACK:  lb_reg     <= pwdata[10:0];
                    REG_MIN_HIT:   minhit_reg <= pwdata[13:0];
                    REG_THRESHOLD: thr_reg    <= pwdata[22:0];
                    REG_MIN_OFF:   minoff_reg <= pwdata[15:0];
                    default:       lb_reg     <= lb_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg    <= s_tuser[1:0];
            sample_reg <= s_tdata[23:0];
            amp_reg    <= s_tdata[46:24];
            trig_reg   <= s_tdata[47];
            rslot_reg  <= s_tdata[51:48];
            rpos_reg   <= s_tdata[65:52];
        end
        if (st_we) begin
            slen_mem[SW'(sc_reg)] <= st_len;
        end
        onset_reg <= onset_next;
        m_reg     <= m_next;
        idx_reg   <= idx_next;
        delay_reg <= delay_next;
        cnt_reg   <= cnt_next;
        pok_reg   <= pok_next;
        evd_reg   <= evd_next;
        evs_reg   <= evs_next;
        evl_reg   <= evl_next;
        evo_reg   <= evo_next;
        rv_reg    <= rv_next;
        rd_reg    <= rd_next;
        md_reg    <= md_next;
    end

    a_active_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (32'(sc_reg) < 32'(HIT_SLOTS)))
        else $error("open hit with no free slot");
    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wp_reg) <= 32'(HIT_DEPTH))
        else $error("write position past hit depth");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= 32'(PREROLL_DEPTH))
        else $error("pre-roll fill count past ring depth");
    a_copy_ends_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY && cnt_reg == '0 && !pend_reg) |=> (state_reg == S_REC))
        else $error("pre-roll copy did not hand over to recording");
endmodule
`default_nettype wire

// ----- src/ahs_ram.sv -----
// ----------------------------------------------------------------------------
// Hit segmenter RAM
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ahs_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire
